// ===== hw/rtl/bpe_pkg.sv =====
// shared types, constants and fixed-point helpers of the bezier point evaluator
package bpe_pkg;

    localparam int COORD_BITS      = 20;
    localparam int PARAM_FRAC_BITS = 16;
    localparam int MAX_POINTS      = 4;

    localparam int PARAM_BITS  = PARAM_FRAC_BITS + 1;
    localparam int WEIGHT_BITS = PARAM_BITS + 2;
    localparam int PACK_BITS   = 3 * COORD_BITS;
    localparam int PROD_BITS   = COORD_BITS + WEIGHT_BITS + 1;
    localparam int SUM_BITS    = PROD_BITS + 2;
    localparam int CNT_BITS    = 3;

    localparam logic [PARAM_BITS-1:0] ONE_T  = PARAM_BITS'(1) << PARAM_FRAC_BITS;
    localparam logic [PARAM_BITS-1:0] HALF_T = PARAM_BITS'(1) << (PARAM_FRAC_BITS - 1);

    // register indexes
    localparam logic [2:0] REG_POINT_COUNT = 3'd0;
    localparam logic [2:0] REG_POINT_ZERO  = 3'd1;
    localparam logic [2:0] REG_POINT_ONE   = 3'd2;
    localparam logic [2:0] REG_POINT_TWO   = 3'd3;
    localparam logic [2:0] REG_POINT_THREE = 3'd4;

    localparam logic [CNT_BITS-1:0]  RESET_COUNT = 3'd3;
    localparam logic [PACK_BITS-1:0] RESET_P0    = 60'd562949953421568;
    localparam logic [PACK_BITS-1:0] RESET_P1    = 60'd562953711520256;
    localparam logic [PACK_BITS-1:0] RESET_P2    = 60'd3659174697243392;
    localparam logic [PACK_BITS-1:0] RESET_P3    = 60'd0;

    localparam logic [CNT_BITS-1:0] CUBIC_COUNT = CNT_BITS'(4);
    localparam bit CUBIC_ALLOWED = (MAX_POINTS >= 4);

    typedef logic [PARAM_BITS-1:0]         t_param;
    typedef logic [WEIGHT_BITS-1:0]        t_weight;
    typedef logic signed [COORD_BITS-1:0]  t_coord;
    typedef logic [PACK_BITS-1:0]          t_pack;
    typedef logic [3:0][PACK_BITS-1:0]     t_points;
    typedef logic [3:0][WEIGHT_BITS-1:0]   t_weights;

    // round-half-up fixed-point product, result stays at most ONE_T for inputs at most ONE_T
    function automatic t_param fmul(input t_param a, input t_param b);
        logic [2*PARAM_BITS-1:0] prod;
        prod = a * b + {{PARAM_BITS{1'b0}}, HALF_T};
        return prod[PARAM_FRAC_BITS +: PARAM_BITS];
    endfunction

endpackage

// ===== hw/rtl/bezier_point_evaluator_core.sv =====
// Bezier point evaluator: quadratic or cubic 3D curve point per parameter word.
// One word in and one word out per cycle as long as i_out_stall stays low. A
// word passes five register stages: clamp, first Bernstein products, weights,
// coordinate-weight products, then sum with rounding and saturation. The curve
// degree is point_count (4 or more is cubic) and control points are packed
// x,y,z Q11.8; write them over APB only while no word is in flight. Registers
// sit at byte address 8*index.
module bezier_point_evaluator_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [5:0]         paddr,
    input  logic [63:0]        pwdata,
    output logic [63:0]        prdata,
    output logic               pready,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  bpe_pkg::t_param    i_curve_param,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output bpe_pkg::t_coord    o_point_x,
    output bpe_pkg::t_coord    o_point_y,
    output bpe_pkg::t_coord    o_point_z
);
    import bpe_pkg::*;

    logic     cubic;
    t_points  points;
    logic     w_valid, w_stall;
    t_weights weights;

    bpe_cfg_regs u_cfg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .o_cubic  (cubic),
        .o_points (points)
    );

    bpe_weight_pipe u_weight (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cubic   (cubic),
        .i_valid   (i_in_valid),
        .i_param   (i_curve_param),
        .o_stall   (o_in_stall),
        .o_valid   (w_valid),
        .o_weights (weights),
        .i_stall   (w_stall)
    );

    bpe_blend_pipe u_blend (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_points  (points),
        .i_valid   (w_valid),
        .i_weights (weights),
        .o_stall   (w_stall),
        .o_valid   (o_out_valid),
        .o_point_x (o_point_x),
        .o_point_y (o_point_y),
        .o_point_z (o_point_z),
        .i_stall   (i_out_stall)
    );

    // input backs up only when every stage holds a word behind a stalled output
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall && w_valid && w_stall))
        else $error("input stalled with room in the pipeline");

endmodule

// ===== hw/rtl/bpe_cfg_regs.sv =====
// apb register file: point count and the four packed control points
module bpe_cfg_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [5:0]                    paddr,
    input  logic [63:0]                   pwdata,
    output logic [63:0]                   prdata,
    output logic                          pready,
    output logic                          o_cubic,
    output bpe_pkg::t_points              o_points
);
    import bpe_pkg::*;

    logic [CNT_BITS-1:0] r_point_count;
    t_points             r_points;
    logic                wr_en;
    logic [2:0]          reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[5:3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_point_count <= RESET_COUNT;
            r_points[0]   <= RESET_P0;
            r_points[1]   <= RESET_P1;
            r_points[2]   <= RESET_P2;
            r_points[3]   <= RESET_P3;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_POINT_COUNT: r_point_count <= pwdata[CNT_BITS-1:0];
                REG_POINT_ZERO:  r_points[0]   <= pwdata[PACK_BITS-1:0];
                REG_POINT_ONE:   r_points[1]   <= pwdata[PACK_BITS-1:0];
                REG_POINT_TWO:   r_points[2]   <= pwdata[PACK_BITS-1:0];
                REG_POINT_THREE: r_points[3]   <= pwdata[PACK_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_POINT_COUNT: prdata = {{(64-CNT_BITS){1'b0}}, r_point_count};
            REG_POINT_ZERO:  prdata = {{(64-PACK_BITS){1'b0}}, r_points[0]};
            REG_POINT_ONE:   prdata = {{(64-PACK_BITS){1'b0}}, r_points[1]};
            REG_POINT_TWO:   prdata = {{(64-PACK_BITS){1'b0}}, r_points[2]};
            REG_POINT_THREE: prdata = {{(64-PACK_BITS){1'b0}}, r_points[3]};
            default:         prdata = 64'd0;
        endcase
    end

    assign o_cubic  = CUBIC_ALLOWED && (r_point_count >= CUBIC_COUNT);
    assign o_points = r_points;

endmodule

// ===== hw/rtl/bpe_weight_pipe.sv =====
// three-stage bernstein weight pipeline: clamp, first products, weights
module bpe_weight_pipe (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cubic,
    input  logic                 i_valid,
    input  bpe_pkg::t_param      i_param,
    output logic                 o_stall,
    output logic                 o_valid,
    output bpe_pkg::t_weights    o_weights,
    input  logic                 i_stall
);
    import bpe_pkg::*;

    logic     r_v1, r_v2, r_v3;
    logic     rdy1, rdy2, rdy3;
    t_param   r_t1, r_u1, r_t2, r_u2;
    t_param   r_tt2, r_uu2, r_tu2;
    t_weights r_w3;
    t_param   n_t1;
    t_weights n_w3;

    assign rdy3    = !r_v3 || !i_stall;
    assign rdy2    = !r_v2 || rdy3;
    assign rdy1    = !r_v1 || rdy2;
    assign o_stall = !rdy1;

    assign n_t1 = (i_param > ONE_T) ? ONE_T : i_param;

    always_comb begin
        if (i_cubic) begin
            n_w3[0] = WEIGHT_BITS'(fmul(r_uu2, r_u2));
            n_w3[1] = WEIGHT_BITS'(fmul(r_t2, r_uu2)) * WEIGHT_BITS'(3);
            n_w3[2] = WEIGHT_BITS'(fmul(r_tt2, r_u2)) * WEIGHT_BITS'(3);
            n_w3[3] = WEIGHT_BITS'(fmul(r_tt2, r_t2));
        end else begin
            n_w3[0] = WEIGHT_BITS'(r_uu2);
            n_w3[1] = WEIGHT_BITS'(r_tu2) << 1;
            n_w3[2] = WEIGHT_BITS'(r_tt2);
            n_w3[3] = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= i_valid;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r_t1 <= n_t1;
            r_u1 <= ONE_T - n_t1;
        end
        if (rdy2) begin
            r_t2  <= r_t1;
            r_u2  <= r_u1;
            r_tt2 <= fmul(r_t1, r_t1);
            r_uu2 <= fmul(r_u1, r_u1);
            r_tu2 <= fmul(r_t1, r_u1);
        end
        if (rdy3) r_w3 <= n_w3;
    end

    assign o_valid   = r_v3;
    assign o_weights = r_w3;

    // weights form a partition of one up to rounding
    logic [WEIGHT_BITS+1:0] w_sum;
    assign w_sum = (WEIGHT_BITS+2)'(r_w3[0]) + (WEIGHT_BITS+2)'(r_w3[1])
                 + (WEIGHT_BITS+2)'(r_w3[2]) + (WEIGHT_BITS+2)'(r_w3[3]);

    a_weight_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 |-> (w_sum <= (WEIGHT_BITS+2)'(ONE_T) + (WEIGHT_BITS+2)'(16))
              && (w_sum + (WEIGHT_BITS+2)'(16) >= (WEIGHT_BITS+2)'(ONE_T)))
        else $error("bernstein weights do not sum to one");

    a_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 |-> (r_t1 <= ONE_T) && (r_t1 + r_u1 == ONE_T))
        else $error("clamped parameter out of range");

endmodule

// ===== hw/rtl/bpe_blend_pipe.sv =====
// two-stage blend: coordinate times weight, then sum, round and saturate
module bpe_blend_pipe (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  bpe_pkg::t_points      i_points,
    input  logic                  i_valid,
    input  bpe_pkg::t_weights     i_weights,
    output logic                  o_stall,
    output logic                  o_valid,
    output bpe_pkg::t_coord       o_point_x,
    output bpe_pkg::t_coord       o_point_y,
    output bpe_pkg::t_coord       o_point_z,
    input  logic                  i_stall
);
    import bpe_pkg::*;

    localparam int SHIFT_BITS = SUM_BITS - PARAM_FRAC_BITS;
    localparam logic signed [SHIFT_BITS-1:0] MAX_C =
        SHIFT_BITS'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
    localparam logic signed [SHIFT_BITS-1:0] MIN_C = -MAX_C - SHIFT_BITS'(1);

    logic r_v4, r_v5, rdy4, rdy5;
    logic signed [PROD_BITS-1:0] r_prod [3][4];
    t_coord r_out [3];
    t_coord n_out [3];

    assign rdy5    = !r_v5 || !i_stall;
    assign rdy4    = !r_v4 || rdy5;
    assign o_stall = !rdy4;

    always_comb begin
        logic signed [SUM_BITS-1:0]   sum;
        logic signed [SHIFT_BITS-1:0] r;
        for (int a = 0; a < 3; a++) begin
            sum = SUM_BITS'(r_prod[a][0]) + SUM_BITS'(r_prod[a][1])
                + SUM_BITS'(r_prod[a][2]) + SUM_BITS'(r_prod[a][3])
                + $signed({{(SUM_BITS-PARAM_BITS){1'b0}}, HALF_T});
            r = SHIFT_BITS'(sum >>> PARAM_FRAC_BITS);
            if (r > MAX_C)      n_out[a] = COORD_BITS'(MAX_C);
            else if (r < MIN_C) n_out[a] = COORD_BITS'(MIN_C);
            else                n_out[a] = COORD_BITS'(r);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (rdy4) r_v4 <= i_valid;
            if (rdy5) r_v5 <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy4) begin
            for (int a = 0; a < 3; a++) begin
                for (int i = 0; i < 4; i++) begin
                    r_prod[a][i] <= $signed(i_points[i][a*COORD_BITS +: COORD_BITS])
                                  * $signed({1'b0, i_weights[i]});
                end
            end
        end
        if (rdy5) begin
            for (int a = 0; a < 3; a++) r_out[a] <= n_out[a];
        end
    end

    assign o_valid   = r_v5;
    assign o_point_x = r_out[0];
    assign o_point_y = r_out[1];
    assign o_point_z = r_out[2];

endmodule
